### src/rlpg_pkg.sv
// ----------------------------------------------------------------------------
// rlpg_pkg
// Shared constants, types and command format for the road layer pixel path.
// ----------------------------------------------------------------------------
package rlpg_pkg;

    localparam int BITMAP_ROWS = 256;
    localparam int ROW_BYTES   = 512;
    localparam int LINE_PIXELS = 320;

    localparam int BITMAP_SIZE = BITMAP_ROWS * ROW_BYTES;
    localparam int MEM_AW      = $clog2(BITMAP_SIZE);
    localparam int POS_W       = $clog2(ROW_BYTES);
    localparam int ROW_W       = 8;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 16;
    localparam int INDEX_W   = 13;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    localparam logic [15:0] SHIFT_BIAS = 16'h0550;
    localparam int          FILL_BIT   = 11;

    localparam logic [INDEX_W-1:0] IDX_DISABLED = 13'h1720;
    localparam logic [INDEX_W-1:0] IDX_FILL     = 13'h1780;
    localparam logic [INDEX_W-1:0] IDX_BG       = 13'h1730;
    localparam logic [INDEX_W-1:0] IDX_ROAD3    = 13'h1708;
    localparam logic [INDEX_W-1:0] IDX_ROAD2    = 13'h170a;
    localparam logic [INDEX_W-1:0] IDX_ROAD1    = 13'h170c;
    localparam logic [INDEX_W-1:0] IDX_ROAD4    = 13'h170e;

    localparam logic [7:0] PIX_BG    = 8'd0;
    localparam logic [7:0] PIX_ROAD1 = 8'd1;
    localparam logic [7:0] PIX_ROAD2 = 8'd2;
    localparam logic [7:0] PIX_ROAD3 = 8'd3;
    localparam logic [7:0] PIX_ROAD4 = 8'd4;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_INDEX,
        CMD_ROAD
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [MEM_AW-1:0]   addr_a;
        logic [MEM_AW-1:0]   addr_b;
        logic                ok_a;
        logic                ok_b;
        logic [7:0]          data;
        logic [INDEX_W-1:0]  index;
        logic [3:0]          flip;
        logic [3:0]          bg;
    } cmd_t;

endpackage

### src/rlpg_front.sv
// ----------------------------------------------------------------------------
// rlpg_front
// Unpacks input words, resolves road positions and classifies each word.
// ----------------------------------------------------------------------------
module rlpg_front (
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic                            s_tuser,
    input  logic [rlpg_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            layer_enable,
    output logic                            push,
    output rlpg_pkg::cmd_t                  cmd
);
    import rlpg_pkg::*;

    logic [16:0]        addr;
    logic [7:0]         wbyte;
    logic [15:0]        vert;
    logic [15:0]        sh_a;
    logic [15:0]        sh_b;
    logic [15:0]        flip;
    logic [8:0]         col;
    logic [ROW_W-1:0]   row;
    logic               row_ok;
    logic               col_ok;
    logic               wr_ok;
    logic [17:0]        diff_a;
    logic [17:0]        diff_b;
    logic [ROW_W+POS_W-1:0] full_a;
    logic [ROW_W+POS_W-1:0] full_b;

    assign addr  = s_tdata[16:0];
    assign wbyte = s_tdata[24:17];
    assign vert  = s_tdata[40:25];
    assign sh_a  = s_tdata[56:41];
    assign sh_b  = s_tdata[72:57];
    assign flip  = s_tdata[88:73];
    assign col   = s_tdata[97:89];

    assign row    = vert[8:1];
    assign row_ok = {1'b0, row} < 9'(BITMAP_ROWS);
    assign col_ok = {1'b0, col} < 10'(LINE_PIXELS);
    assign wr_ok  = {1'b0, addr} < 18'(BITMAP_SIZE);

    assign diff_a = {2'b00, sh_a} + {9'd0, col} - {2'b00, SHIFT_BIAS};
    assign diff_b = {2'b00, sh_b} + {9'd0, col} - {2'b00, SHIFT_BIAS};
    assign full_a = {row, diff_a[POS_W-1:0]};
    assign full_b = {row, diff_b[POS_W-1:0]};

    assign push = s_tvalid && s_tready && ((s_tuser == OP_RENDER) ? col_ok : wr_ok);

    always_comb begin
        cmd        = '0;
        cmd.data   = wbyte;
        cmd.flip   = flip[3:0];
        cmd.bg     = flip[11:8];
        cmd.ok_a   = row_ok && (diff_a[17:POS_W] == '0);
        cmd.ok_b   = row_ok && (diff_b[17:POS_W] == '0);
        cmd.addr_a = full_a[MEM_AW-1:0];
        cmd.addr_b = full_b[MEM_AW-1:0];
        cmd.index  = IDX_DISABLED;
        if (s_tuser == OP_WRITE) begin
            cmd.kind   = CMD_WRITE;
            cmd.addr_a = addr[MEM_AW-1:0];
        end else if (!layer_enable) begin
            cmd.kind   = CMD_INDEX;
        end else if (vert[FILL_BIT]) begin
            cmd.kind   = CMD_INDEX;
            cmd.index  = IDX_FILL + {6'd0, vert[6:0]};
        end else begin
            cmd.kind   = CMD_ROAD;
        end
    end

endmodule

### src/rlpg_fifo.sv
// ----------------------------------------------------------------------------
// rlpg_fifo
// Short command queue between the classifier and the bitmap stage.
// ----------------------------------------------------------------------------
module rlpg_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  rlpg_pkg::cmd_t  push_cmd,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output rlpg_pkg::cmd_t  head_cmd
);
    import rlpg_pkg::*;

    cmd_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg;
    logic [QUEUE_CW-1:0] count_next;
    logic                do_pop;

    assign full      = count_reg == QUEUE_CW'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head_cmd  = slot_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_comb begin
        count_next = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

### src/rlpg_back.sv
// ----------------------------------------------------------------------------
// rlpg_back
// Road bitmap memory, dual pixel read, color selection and output register.
// ----------------------------------------------------------------------------
module rlpg_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cmd_valid,
    input  rlpg_pkg::cmd_t                  cmd,
    output logic                            cmd_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rlpg_pkg::M_TDATA_W-1:0]  m_tdata
);
    import rlpg_pkg::*;

    logic [7:0]         bitmap_mem [BITMAP_SIZE];
    logic [7:0]         rd_a_reg;
    logic [7:0]         rd_b_reg;
    logic               s1_valid_reg;
    cmd_kind_t          s1_kind_reg;
    logic               s1_ok_a_reg;
    logic               s1_ok_b_reg;
    logic [INDEX_W-1:0] s1_index_reg;
    logic [3:0]         s1_flip_reg;
    logic [3:0]         s1_bg_reg;
    logic               out_valid_reg;
    logic [INDEX_W-1:0] out_index_reg;
    logic               advance;
    logic [7:0]         pix_a;
    logic [7:0]         pix_b;
    logic [7:0]         pix;
    logic               res_valid;
    logic [INDEX_W-1:0] res_index;

    assign advance = !out_valid_reg || m_tready;
    assign cmd_pop = advance && cmd_valid;

    always_ff @(posedge aclk) begin
        if (cmd_pop && cmd.kind == CMD_WRITE) begin
            bitmap_mem[cmd.addr_a] <= cmd.data;
        end
        if (cmd_pop) begin
            rd_a_reg <= bitmap_mem[cmd.addr_a];
            rd_b_reg <= bitmap_mem[cmd.addr_b];
        end
    end

    assign pix_a = s1_ok_a_reg ? rd_a_reg : PIX_BG;
    assign pix_b = s1_ok_b_reg ? rd_b_reg : PIX_BG;
    assign pix   = (pix_b > pix_a) ? pix_b : pix_a;

    always_comb begin
        res_valid = 1'b0;
        res_index = s1_index_reg;
        unique case (s1_kind_reg)
            CMD_WRITE: res_valid = 1'b0;
            CMD_INDEX: res_valid = s1_valid_reg;
            CMD_ROAD: begin
                res_valid = s1_valid_reg;
                unique case (pix)
                    PIX_BG:    res_index = IDX_BG + {9'd0, s1_bg_reg};
                    PIX_ROAD3: res_index = IDX_ROAD3 + {12'd0, s1_flip_reg[0]};
                    PIX_ROAD2: res_index = IDX_ROAD2 + {12'd0, s1_flip_reg[1]};
                    PIX_ROAD1: res_index = IDX_ROAD1 + {12'd0, s1_flip_reg[2]};
                    PIX_ROAD4: res_index = IDX_ROAD4 + {12'd0, s1_flip_reg[3]};
                    default:   res_valid = 1'b0;
                endcase
            end
            default: res_valid = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd_pop) begin
            s1_kind_reg  <= cmd.kind;
            s1_ok_a_reg  <= cmd.ok_a;
            s1_ok_b_reg  <= cmd.ok_b;
            s1_index_reg <= cmd.index;
            s1_flip_reg  <= cmd.flip;
            s1_bg_reg    <= cmd.bg;
        end
        if (advance && res_valid) begin
            out_index_reg <= res_index;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg  <= cmd_valid;
            out_valid_reg <= res_valid;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, 1'b1, out_index_reg};

endmodule

### src/road_layer_pixel_generator_core.sv
// ----------------------------------------------------------------------------
// road_layer_pixel_generator_core
// Road layer pixel generator: bitmap store and per-pixel palette index.
// ----------------------------------------------------------------------------
// Takes one word per clock, bitmap writes and pixel renders alike, while the
// command queue is not full, and gives up to one result per clock while the
// output is not stalled. A render result passes the command queue, then the
// bitmap read register, and sits in the output register until it is taken.
// The rate is set by the 128 KiB bitmap memory, which serves one write and two
// reads per cycle. The bitmap has no clearing pass and is ready right after
// reset; pixels must only read bytes that were written. Out-of-range writes,
// out-of-line columns and pixel values above 4 give no result.
module road_layer_pixel_generator_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic                            cfg_wdata,   // road_layer_enabled
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic                            s_tuser,     // op
    // bitmap_address, bitmap_byte, line_vertical, shift_first, shift_second,
    // line_flip, pixel_column
    input  logic [rlpg_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rlpg_pkg::M_TDATA_W-1:0]  m_tdata      // palette_index, pixel_written
);
    import rlpg_pkg::*;

    logic enable_reg;
    logic push;
    logic pop;
    logic full;
    logic not_empty;
    cmd_t push_cmd;
    cmd_t head_cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b1;
        end else if (cfg_we) begin
            enable_reg <= cfg_wdata;
        end
    end

    assign s_tready = !full;

    rlpg_front u_front (
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tuser      (s_tuser),
        .s_tdata      (s_tdata),
        .layer_enable (enable_reg),
        .push         (push),
        .cmd          (push_cmd)
    );

    rlpg_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .head_cmd  (head_cmd)
    );

    rlpg_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (not_empty),
        .cmd       (head_cmd),
        .cmd_pop   (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

### src/rlpg_checker.sv
// ----------------------------------------------------------------------------
// rlpg_checker
// Port-level checks on the result stream of the road layer pixel generator.
// ----------------------------------------------------------------------------
module rlpg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_written: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[13] && m_tdata[15:14] == 2'b00)
        else $error("result without pixel_written or stray pad bits");

    a_bank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[12:8] == 5'h17)
        else $error("palette index outside road layer bank");

    a_disabled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[12:4] == 9'h172 |-> m_tdata[3:0] == 4'h0)
        else $error("unused index in disabled-layer range");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind road_layer_pixel_generator_core rlpg_checker u_rlpg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Road layer pixel generator testbench
// Loads bitmap bytes and renders pixels through the stream ports. A local
// model of the bitmap and the layer enable predicts each palette index, and
// every result word is checked against the oldest prediction. Both stream
// sides stall at random, except in one steady stretch.
// ----------------------------------------------------------------------------
module testbench;
    import rlpg_pkg::*;

    typedef struct {
        logic [INDEX_W-1:0] palette_index;
        logic               pixel_written;
    } pixel_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic                 cfg_wdata = 1'b1;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic                 s_tuser   = OP_WRITE;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    logic [7:0]    road_bitmap [BITMAP_SIZE];
    bit            written_map [BITMAP_SIZE];
    logic          layer_enabled = 1'b1;
    pixel_result_t pending_pixels [$];
    pixel_result_t oldest_pixel;
    int            fail_count = 0;
    int            words_sent = 0;
    bit            steady     = 1'b0;

    road_layer_pixel_generator_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(5_000_000);
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 9);
    end

    // ---- bitmap and palette model ----
    function automatic logic [7:0] bitmap_pixel(input logic [7:0] row,
                                                input logic [15:0] shift,
                                                input logic [8:0] col);
        int p;
        p = int'(shift) + int'(col) - int'(SHIFT_BIAS);
        if (p < 0 || p >= ROW_BYTES || int'(row) >= BITMAP_ROWS)
            return PIX_BG;
        return road_bitmap[int'(row) * ROW_BYTES + p];
    endfunction

    function automatic logic palette_for_pixel(input logic [15:0] vert, sh0, sh1, flip,
                                               input logic [8:0] col,
                                               output logic [INDEX_W-1:0] idx);
        logic [7:0] pa;
        logic [7:0] pb;
        logic [7:0] pix;
        idx = '0;
        if (col >= LINE_PIXELS)
            return 1'b0;
        if (!layer_enabled) begin
            idx = IDX_DISABLED;
        end else if (vert[FILL_BIT]) begin
            idx = IDX_FILL + {6'd0, vert[6:0]};
        end else begin
            pa  = bitmap_pixel(vert[8:1], sh0, col);
            pb  = bitmap_pixel(vert[8:1], sh1, col);
            pix = (pb > pa) ? pb : pa;
            case (pix)
                PIX_BG:    idx = IDX_BG + {9'd0, flip[11:8]};
                PIX_ROAD3: idx = IDX_ROAD3 + {12'd0, flip[0]};
                PIX_ROAD2: idx = IDX_ROAD2 + {12'd0, flip[1]};
                PIX_ROAD1: idx = IDX_ROAD1 + {12'd0, flip[2]};
                PIX_ROAD4: idx = IDX_ROAD4 + {12'd0, flip[3]};
                default:   return 1'b0;
            endcase
        end
        return 1'b1;
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_word(input logic [16:0] addr,
                                                       input logic [7:0] value,
                                                       input logic [15:0] vert, sh0, sh1,
                                                       input logic [15:0] flip,
                                                       input logic [8:0] col);
        return {6'b0, col, flip, sh1, sh0, vert, value, addr};
    endfunction

    // accepted word: update bitmap or queue the predicted pixel
    function automatic void apply_word(input logic op, input logic [S_TDATA_W-1:0] w);
        logic [INDEX_W-1:0] idx;
        pixel_result_t      r;
        if (op == OP_WRITE) begin
            if (int'(w[16:0]) < BITMAP_SIZE) begin
                road_bitmap[w[16:0]] = w[24:17];
                written_map[w[16:0]] = 1'b1;
            end
        end else if (palette_for_pixel(w[40:25], w[56:41], w[72:57], w[88:73],
                                       w[97:89], idx)) begin
            r.palette_index = idx;
            r.pixel_written = 1'b1;
            pending_pixels.push_back(r);
        end
    endfunction

    // ---- result checker ----
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected word, actual palette_index=%h pixel_written=%b",
                         $time, m_tdata[12:0], m_tdata[13]);
                fail_count++;
            end else begin
                oldest_pixel = pending_pixels.pop_front();
                if (m_tdata[12:0] !== oldest_pixel.palette_index) begin
                    $display("%0t: palette_index expected %h actual %h", $time,
                             oldest_pixel.palette_index, m_tdata[12:0]);
                    fail_count++;
                end
                if (m_tdata[13] !== oldest_pixel.pixel_written) begin
                    $display("%0t: pixel_written expected %b actual %b", $time,
                             oldest_pixel.pixel_written, m_tdata[13]);
                    fail_count++;
                end
            end
        end
    end

    // ---- stimulus helpers ----
    task automatic send_word(input logic op, input logic [S_TDATA_W-1:0] w);
        while (!steady && $urandom_range(99) < 9) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= w;
        do @(posedge aclk); while (!s_tready);
        apply_word(op, w);
        words_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_layer_enabled(input logic en);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= en;
        @(posedge aclk);
        cfg_we        <= 1'b0;
        layer_enabled  = en;
    endtask

    function automatic logic [7:0] random_pixel();
        if ($urandom_range(99) < 85)
            return 8'($urandom_range(4));
        return 8'($urandom_range(255));
    endfunction

    task automatic write_byte(input int addr, input logic [7:0] value);
        send_word(OP_WRITE, pack_word(17'(addr), value, 16'($urandom), 16'($urandom),
                                      16'($urandom), 16'($urandom), 9'($urandom_range(511))));
    endtask

    // bytes that a render will read must hold data first
    task automatic fill_if_unwritten(input logic [15:0] vert, sh, input logic [8:0] col);
        int p;
        int addr;
        p = int'(sh) + int'(col) - int'(SHIFT_BIAS);
        if (p >= 0 && p < ROW_BYTES) begin
            addr = int'(vert[8:1]) * ROW_BYTES + p;
            if (!written_map[addr])
                write_byte(addr, random_pixel());
        end
    endtask

    task automatic render_pixel(input logic [15:0] vert, sh0, sh1, flip,
                                input logic [8:0] col);
        fill_if_unwritten(vert, sh0, col);
        fill_if_unwritten(vert, sh1, col);
        send_word(OP_RENDER, pack_word(17'($urandom), 8'($urandom), vert, sh0, sh1,
                                       flip, col));
    endtask

    function automatic logic [15:0] shift_for(input int pos, input logic [8:0] col);
        return 16'(pos + int'(SHIFT_BIAS) - int'(col));
    endfunction

    task automatic random_render();
        logic [15:0] vert;
        logic [15:0] sh0;
        logic [15:0] sh1;
        logic [8:0]  col;
        if ($urandom_range(9) == 0)
            col = 9'($urandom_range(511, LINE_PIXELS));
        else
            col = 9'($urandom_range(LINE_PIXELS - 1));
        vert           = 16'($urandom);
        vert[FILL_BIT] = ($urandom_range(99) < 15);
        sh0 = ($urandom_range(9) == 0) ? 16'($urandom)
                                       : shift_for($urandom_range(527) - 8, col);
        sh1 = ($urandom_range(9) == 0) ? 16'($urandom)
                                       : shift_for($urandom_range(527) - 8, col);
        render_pixel(vert, sh0, sh1, 16'($urandom), col);
    endtask

    // ---- tests ----
    task automatic test_random_traffic(input int n_words);
        int start;
        start = words_sent;
        while (words_sent - start < n_words) begin
            if ($urandom_range(99) < 25)
                write_byte($urandom_range(BITMAP_SIZE - 1), random_pixel());
            else
                random_render();
        end
    endtask

    task automatic test_directed_pixels();
        int base;
        base = 5 * ROW_BYTES;
        write_byte(base + 10, PIX_ROAD3);
        write_byte(base + 11, PIX_ROAD2);
        write_byte(base + 12, PIX_ROAD1);
        write_byte(base + 13, PIX_ROAD4);
        write_byte(base + 14, PIX_BG);
        write_byte(base + 15, 8'd7);
        write_byte(base + 16, 8'hff);
        render_pixel(16'h000a, shift_for(10, 0), shift_for(14, 0), 16'h0000, 9'd0);
        render_pixel(16'h000a, shift_for(10, 0), shift_for(14, 0), 16'hffff, 9'd0);
        render_pixel(16'h000a, shift_for(11, 0), shift_for(14, 0), 16'h0002, 9'd0);
        render_pixel(16'h000a, shift_for(12, 0), shift_for(14, 0), 16'h0004, 9'd0);
        render_pixel(16'h000a, shift_for(13, 0), shift_for(14, 0), 16'h0008, 9'd0);
        render_pixel(16'h000a, shift_for(14, 0), shift_for(14, 0), 16'h0f00, 9'd0);
        render_pixel(16'h000a, shift_for(15, 0), shift_for(14, 0), 16'h0000, 9'd0);
        render_pixel(16'h000a, shift_for(14, 0), shift_for(16, 0), 16'h0000, 9'd0);
        render_pixel(16'h000a, shift_for(12, 0), shift_for(13, 0), 16'h0000, 9'd0);
        render_pixel(16'h000a, shift_for(11, 0), shift_for(10, 0), 16'h0001, 9'd0);
        // both positions off the row
        render_pixel(16'h000a, 16'h0000, 16'hffff, 16'h0a00, 9'd0);
        render_pixel(16'h0fff, 16'h0000, 16'h0000, 16'h0000, 9'd0);
        render_pixel(16'hf800, 16'hffff, 16'hffff, 16'hffff, 9'd0);
        // last row, row edges, last column of the line and columns past the line
        write_byte(255 * ROW_BYTES, PIX_ROAD4);
        write_byte(255 * ROW_BYTES + ROW_BYTES - 1, PIX_ROAD1);
        render_pixel(16'h01fe, shift_for(0, 319), shift_for(ROW_BYTES - 1, 319),
                     16'h0000, 9'd319);
        render_pixel(16'h000a, shift_for(10, 320), shift_for(10, 320), 16'h0000, 9'd320);
        render_pixel(16'h000a, shift_for(10, 511), shift_for(10, 511), 16'h0000, 9'd511);
    endtask

    task automatic test_layer_disabled();
        set_layer_enabled(1'b0);
        render_pixel(16'h000a, shift_for(10, 0), shift_for(14, 0), 16'hffff, 9'd0);
        render_pixel(16'h0fff, 16'h0000, 16'h0000, 16'h0000, 9'd0);
        render_pixel(16'h000a, shift_for(15, 0), shift_for(16, 0), 16'h0000, 9'd0);
        render_pixel(16'h000a, shift_for(10, 400), shift_for(10, 400), 16'h0000, 9'd400);
        test_random_traffic(100);
        set_layer_enabled(1'b1);
    endtask

    task automatic test_steady_stream(input int n_words);
        wait_idle();
        steady = 1'b1;
        test_random_traffic(n_words);
        wait_idle();
        steady = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_pixels();
        set_layer_enabled(1'b1);
        test_random_traffic(300);
        test_layer_disabled();
        test_steady_stream(200);
        test_random_traffic(200);
        wait_idle();
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
